// ===== rtl/core/rswd_pkg.sv =====
// Shared types and constants for the rounded signed 64-by-32 divider.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rswd_pkg;

    localparam int NUM_W         = 64;
    localparam int DEN_W         = 32;
    localparam int STAT_W        = 2;
    localparam int STEPS_PER_STG = 2;
    localparam int DIV_STAGES    = NUM_W / STEPS_PER_STG;

    // status codes
    localparam logic [STAT_W-1:0] ST_NORMAL    = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    // saturation values for a zero divisor
    localparam logic [NUM_W-1:0] SAT_POS = {1'b0, {(NUM_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] SAT_NEG = {1'b1, {(NUM_W-1){1'b0}}};

    // word carried between divider stages
    typedef struct packed {
        logic [DEN_W-1:0] rem;      // partial remainder, below dmag for a nonzero divisor
        logic [NUM_W-1:0] nq;       // dividend bits shift out, quotient bits shift in
        logic [DEN_W-1:0] dmag;     // divisor magnitude
        logic             neg;      // quotient takes a minus sign
        logic             dzero;    // divisor was zero
        logic             num_neg;  // dividend was negative
    } t_stage;

    // finished result word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [NUM_W-1:0]  quotient;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/rswd_prep.sv =====
// Input stage: strips operand signs and adds half the divisor for rounding.
// Depends on rswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rswd_prep
    import rswd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic                  o_valid,
    output t_stage                o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    // take magnitudes and add the rounding half
    always_comb begin
        logic [NUM_W-1:0] v_mag;
        logic [DEN_W-1:0] v_dmag;
        v_mag  = i_dividend[NUM_W-1] ? (NUM_W'(0) - i_dividend) : i_dividend;
        v_dmag = i_divisor[DEN_W-1] ? (DEN_W'(0) - i_divisor) : i_divisor;
        n_data.rem     = '0;
        n_data.nq      = v_mag + {{(NUM_W-DEN_W){1'b0}}, (v_dmag >> 1)};
        n_data.dmag    = v_dmag;
        n_data.neg     = i_dividend[NUM_W-1] ^ i_divisor[DEN_W-1];
        n_data.dzero   = (i_divisor == '0);
        n_data.num_neg = i_dividend[NUM_W-1];
    end

    // advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/rswd_div_stage.sv =====
// One divider stage: STEPS_PER_STG restoring steps, then a register.
// Depends on rswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rswd_div_stage
    import rswd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_stage i_data,
    output logic        o_valid,
    output t_stage      o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    // shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        logic [DEN_W:0]   v_rem;
        logic [NUM_W-1:0] v_nq;
        logic             v_bit;
        v_rem  = {1'b0, i_data.rem};
        v_nq   = i_data.nq;
        v_bit  = 1'b0;
        for (int k = 0; k < STEPS_PER_STG; k++) begin
            v_rem = {v_rem[DEN_W-1:0], v_nq[NUM_W-1]};
            v_bit = (v_rem >= {1'b0, i_data.dmag});
            if (v_bit) begin
                v_rem = v_rem - {1'b0, i_data.dmag};
            end
            v_nq = {v_nq[NUM_W-2:0], v_bit};
        end
        n_data     = i_data;
        n_data.rem = v_rem[DEN_W-1:0];
        n_data.nq  = v_nq;
    end

    // advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/rswd_post.sv =====
// Final stage: restores the quotient sign and saturates on a zero divisor.
// Depends on rswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rswd_post
    import rswd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_stage i_data,
    output logic        o_valid,
    output t_result     o_data
);

    logic    r_valid;
    t_result r_data;
    t_result n_data;

    // pick the saturated value or the signed quotient
    always_comb begin
        if (i_data.dzero) begin
            n_data.quotient = i_data.num_neg ? SAT_NEG : SAT_POS;
            n_data.status   = i_data.num_neg ? ST_UNDERFLOW : ST_OVERFLOW;
        end else begin
            n_data.quotient = i_data.neg ? (NUM_W'(0) - i_data.nq) : i_data.nq;
            n_data.status   = ST_NORMAL;
        end
    end

    // advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/rswd_skid.sv =====
// Output register with a skid slot; its ready is a register output.
// Depends on rswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rswd_skid
    import rswd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_load_out;
    logic    w_load_skid;
    logic    w_drain_skid;

    // route the incoming word to the output or park it in the skid slot
    assign w_load_out   = !r_skid_valid && (!r_out_valid || i_ready);
    assign w_load_skid  = !r_skid_valid && r_out_valid && !i_ready && i_valid;
    assign w_drain_skid = r_skid_valid && i_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= i_valid;
            end
            if (w_load_skid) begin
                r_skid_valid <= 1'b1;
            end else if (w_drain_skid) begin
                r_skid_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= i_data;
        end else if (w_drain_skid) begin
            r_out <= r_skid;
        end
        if (w_load_skid) begin
            r_skid <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/rounded_signed_wide_divide.sv =====
// Rounded signed 64-by-32 divider, top level.
// Depends on rswd_pkg, rswd_prep, rswd_div_stage, rswd_post and rswd_skid.
//
// Usage:
//   The slave channel takes one division per word: tdata holds the signed
//   dividend in bits 63:0 and the signed divisor in bits 95:64. The master
//   channel returns one word per division: tdata is the signed quotient,
//   rounded to nearest with halves away from zero, and tuser the status
//   (normal, overflow or underflow on a zero divisor).
//   Throughput: one division per cycle while the pipeline is not frozen. The
//   work runs through a prep stage, 32 divider stages of two restoring steps
//   each, a sign/saturate stage and the output register.
//   Reset (synchronous, active low) empties every stage; no memory needs
//   clearing and the block accepts words in the first cycle after reset.
//   When the receiver stalls, a finished result waits in the output register
//   and the next one goes to a skid slot; only when that slot is full does
//   the whole pipeline freeze and s_axis_tready drop. Nothing is lost or
//   repeated across a stall.
`timescale 1ns / 1ps
`default_nettype none

module rounded_signed_wide_divide
    import rswd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [95:0]   s_axis_tdata,   // [63:0] dividend, [95:64] divisor
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [NUM_W-1:0]   m_axis_tdata,   // [63:0] quotient
    output logic [STAT_W-1:0]  m_axis_tuser    // [1:0] status
);

    logic                  w_en;
    logic [DIV_STAGES:0]   w_vld;
    t_stage                w_stg [0:DIV_STAGES];
    logic                  w_post_valid;
    t_result               w_post_data;
    t_result               w_out_data;

    // prep: signs off, rounding half on
    rswd_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (s_axis_tvalid),
        .i_dividend (s_axis_tdata[NUM_W-1:0]),
        .i_divisor  (s_axis_tdata[NUM_W+DEN_W-1:NUM_W]),
        .o_valid    (w_vld[0]),
        .o_data     (w_stg[0])
    );

    // divider stages
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        rswd_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_data  (w_stg[g]),
            .o_valid (w_vld[g+1]),
            .o_data  (w_stg[g+1])
        );
    end

    // sign restore and zero-divisor saturation
    rswd_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vld[DIV_STAGES]),
        .i_data  (w_stg[DIV_STAGES]),
        .o_valid (w_post_valid),
        .o_data  (w_post_data)
    );

    // output register and skid slot; its ready moves the whole pipeline
    rswd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_post_valid),
        .i_data  (w_post_data),
        .o_ready (w_en),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out_data),
        .i_ready (m_axis_tready)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tdata  = w_out_data.quotient;
    assign m_axis_tuser  = w_out_data.status;

    // a frozen pipeline keeps its valid pattern
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_vld))
        else $error("pipeline valid bits moved during a stall");

    // an accepted zero divisor is flagged in the prep stage
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && w_en && (s_axis_tdata[NUM_W+DEN_W-1:NUM_W] == '0))
        |=> (w_vld[0] && w_stg[0].dzero))
        else $error("zero divisor not flagged");

    // a saturated status always comes with its matching value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_NORMAL))
        |-> ((m_axis_tuser == ST_OVERFLOW && m_axis_tdata == SAT_POS)
          || (m_axis_tuser == ST_UNDERFLOW && m_axis_tdata == SAT_NEG)))
        else $error("saturation status and value disagree");

endmodule

`default_nettype wire
